// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the tangent basis block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TTB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/ttb_pkg.sv =====
// Shared widths, vertex type and normalizer status type for the tangent basis block.
package ttb_pkg;

  localparam int COORD_W = 32;   // position and uv width
  localparam int NRM_W   = 16;   // Q1.14 vector component width
  localparam int DIFF_W  = 33;   // exact difference of two coordinates
  localparam int FIT_W   = 31;   // block-shifted difference, magnitude below 2^30
  localparam int VEC_W   = 64;   // unnormalized vector component
  localparam int Q_FRAC  = 14;   // fraction bits of a unit vector component

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] tu;
    logic signed [COORD_W-1:0] tv;
    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
  } vert_t;

  typedef struct packed {
    logic done;   // one-cycle pulse, unit vector ready
    logic zero;   // input vector was zero, unit vector is zero
  } norm_stat_t;

endpackage

// ===== sv/ttb_if.sv =====
// Valid/ready channel interfaces for vertex input and basis result beats.
interface ttb_vertex_if;
  logic valid;
  logic ready;
  logic signed [ttb_pkg::COORD_W-1:0] pos_x;
  logic signed [ttb_pkg::COORD_W-1:0] pos_y;
  logic signed [ttb_pkg::COORD_W-1:0] pos_z;
  logic signed [ttb_pkg::COORD_W-1:0] tex_u;
  logic signed [ttb_pkg::COORD_W-1:0] tex_v;
  logic signed [ttb_pkg::NRM_W-1:0]   norm_x;
  logic signed [ttb_pkg::NRM_W-1:0]   norm_y;
  logic signed [ttb_pkg::NRM_W-1:0]   norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                output ready);
endinterface

interface ttb_result_if;
  logic valid;
  logic ready;
  logic signed [ttb_pkg::NRM_W-1:0] tan_x;
  logic signed [ttb_pkg::NRM_W-1:0] tan_y;
  logic signed [ttb_pkg::NRM_W-1:0] tan_z;
  logic signed [ttb_pkg::NRM_W-1:0] bitan_x;
  logic signed [ttb_pkg::NRM_W-1:0] bitan_y;
  logic signed [ttb_pkg::NRM_W-1:0] bitan_z;
  logic signed [ttb_pkg::NRM_W-1:0] out_norm_x;
  logic signed [ttb_pkg::NRM_W-1:0] out_norm_y;
  logic signed [ttb_pkg::NRM_W-1:0] out_norm_z;
  logic degenerate;
  logic last_of_triangle;

  modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  out_norm_x, out_norm_y, out_norm_z, degenerate, last_of_triangle,
                  input ready);
  modport sink (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                out_norm_x, out_norm_y, out_norm_z, degenerate, last_of_triangle,
                output ready);
endinterface

// ===== sv/triangle_tangent_basis.sv =====
// Tangent basis block: use, channels, timing.
//  vertex : valid/ready sink, one beat per vertex of a triangle list, three
//           vertices to a triangle, in order.
//  result : valid/ready source, three beats after the third vertex of each
//           triangle, one per corner in order 0, 1, 2; last_of_triangle marks
//           the third. The first two vertices give no beat.
//  Sequence: the first two vertices are each stored as they are taken. The
//  third starts a pass per corner: the shared 32x32 multiplier forms the uv
//  determinant (the corner ends there as degenerate when it is zero) and the
//  tangent, the normalizer scales the tangent, the multiplier forms the cross
//  product of the normal and the unit tangent, and the normalizer scales it
//  (block shift, sum of squares, square root, one divide per component). The
//  normalizer's bit-serial root and divide take most of the pass.
//  Ready is high only between triangles' work; a finished beat waits in the
//  output register, and vertex beats are taken while it waits.
//  A stalled receiver holds the block at the corner's end until the previous
//  beat is taken.
//  Reset (rst, synchronous) empties the output register and restarts the
//  triangle at its first vertex.
`include "assert_macros.svh"

module triangle_tangent_basis (
  input  logic          clk,
  input  logic          rst,
  ttb_vertex_if.sink    vertex,
  ttb_result_if.source  result
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_FIT, S_MUL, S_ACC, S_TNORM, S_TWAIT, S_BNORM, S_BWAIT, S_OUT
  } state_t;

  state_t state;
  logic [1:0] slot;
  logic [1:0] corner;
  ttb_pkg::vert_t v0, v1, v2;
  logic signed [ttb_pkg::DIFF_W-1:0] e_raw [6];
  logic signed [ttb_pkg::DIFF_W-1:0] d_raw [4];
  logic signed [ttb_pkg::FIT_W-1:0]  e [6];
  logic signed [ttb_pkg::FIT_W-1:0]  d [4];
  logic [3:0] k;
  logic signed [ttb_pkg::VEC_W-1:0] pr;
  logic signed [ttb_pkg::VEC_W-1:0] acc;
  logic det_neg;
  logic signed [ttb_pkg::VEC_W-1:0] tvec [3];
  logic signed [ttb_pkg::VEC_W-1:0] bvec [3];
  logic signed [ttb_pkg::NRM_W-1:0] tn [3];
  logic signed [ttb_pkg::NRM_W-1:0] bn [3];
  logic degen;
  logic res_valid;
  logic signed [ttb_pkg::NRM_W-1:0] o_tan [3];
  logic signed [ttb_pkg::NRM_W-1:0] o_bit [3];
  logic signed [ttb_pkg::NRM_W-1:0] o_nrm [3];
  logic o_degen;
  logic o_last;

  ttb_pkg::vert_t vin, vc, va, vb;
  logic [ttb_pkg::DIFF_W-1:0] e_or, d_or;
  logic [1:0] e_sh, d_sh;
  logic signed [31:0] opa, opb;
  logic signed [ttb_pkg::VEC_W-1:0] mul_out;
  logic signed [ttb_pkg::VEC_W-1:0] diff;
  logic signed [ttb_pkg::VEC_W-1:0] nvec_x, nvec_y, nvec_z;
  logic n_start;
  logic out_load;
  ttb_pkg::norm_stat_t nstat;
  logic signed [ttb_pkg::NRM_W-1:0] unit_x, unit_y, unit_z;

  function automatic logic signed [32:0] sub33(logic signed [31:0] a, logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [32:0] abs33(logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic [1:0] fit_shift(logic [32:0] o);
    if (o[32])      return 2'd3;
    else if (o[31]) return 2'd2;
    else if (o[30]) return 2'd1;
    else            return 2'd0;
  endfunction

  function automatic logic signed [30:0] fit(logic signed [32:0] x, logic [1:0] s);
    logic [32:0] m;
    m = abs33(x) >> s;
    return x[32] ? 31'(-m) : m[30:0];
  endfunction

  function automatic logic signed [31:0] ext31(logic signed [30:0] x);
    return {x[30], x};
  endfunction

  function automatic logic signed [31:0] ext16(logic signed [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  // Pack the vertex beat
  always_comb begin
    vin.px = vertex.pos_x;
    vin.py = vertex.pos_y;
    vin.pz = vertex.pos_z;
    vin.tu = vertex.tex_u;
    vin.tv = vertex.tex_v;
    vin.nx = vertex.norm_x;
    vin.ny = vertex.norm_y;
    vin.nz = vertex.norm_z;
  end

  // Select the corner and its two partners
  always_comb begin
    unique case (corner)
      2'd0: begin vc = v0; va = v1; vb = v2; end
      2'd1: begin vc = v1; va = v0; vb = v2; end
      2'd2: begin vc = v2; va = v1; vb = v0; end
      default: begin vc = v0; va = v1; vb = v2; end
    endcase
  end

  // Block shift shared by the edges, and a separate one shared by the uv deltas
  always_comb begin
    e_or = '0;
    d_or = '0;
    for (int i = 0; i < 6; i++) e_or = e_or | abs33(e_raw[i]);
    for (int i = 0; i < 4; i++) d_or = d_or | abs33(d_raw[i]);
    e_sh = fit_shift(e_or);
    d_sh = fit_shift(d_or);
  end

  // Multiplier operands by step
  always_comb begin
    unique case (k)
      4'd0:  begin opa = ext31(d[0]);  opb = ext31(d[3]); end
      4'd1:  begin opa = ext31(d[2]);  opb = ext31(d[1]); end
      4'd2:  begin opa = ext31(d[3]);  opb = ext31(e[0]); end
      4'd3:  begin opa = ext31(d[1]);  opb = ext31(e[3]); end
      4'd4:  begin opa = ext31(d[3]);  opb = ext31(e[1]); end
      4'd5:  begin opa = ext31(d[1]);  opb = ext31(e[4]); end
      4'd6:  begin opa = ext31(d[3]);  opb = ext31(e[2]); end
      4'd7:  begin opa = ext31(d[1]);  opb = ext31(e[5]); end
      4'd8:  begin opa = ext16(vc.ny); opb = ext16(tn[2]); end
      4'd9:  begin opa = ext16(vc.nz); opb = ext16(tn[1]); end
      4'd10: begin opa = ext16(vc.nz); opb = ext16(tn[0]); end
      4'd11: begin opa = ext16(vc.nx); opb = ext16(tn[2]); end
      4'd12: begin opa = ext16(vc.nx); opb = ext16(tn[1]); end
      4'd13: begin opa = ext16(vc.ny); opb = ext16(tn[0]); end
      default: begin opa = '0; opb = '0; end
    endcase
    mul_out = opa * opb;
    diff    = acc - pr;
  end

  // Normalizer hookup
  assign n_start = (state == S_TNORM) || (state == S_BNORM);
  assign nvec_x  = (state == S_TNORM) ? tvec[0] : bvec[0];
  assign nvec_y  = (state == S_TNORM) ? tvec[1] : bvec[1];
  assign nvec_z  = (state == S_TNORM) ? tvec[2] : bvec[2];

  ttb_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (n_start),
    .vec_x  (nvec_x),
    .vec_y  (nvec_y),
    .vec_z  (nvec_z),
    .stat   (nstat),
    .unit_x (unit_x),
    .unit_y (unit_y),
    .unit_z (unit_z)
  );

  // Load the output register when the corner is done and the register is free
  assign out_load = (state == S_OUT) && (!res_valid || result.ready);

  // Ports
  assign vertex.ready            = (state == S_IDLE);
  assign result.valid            = res_valid;
  assign result.tan_x            = o_tan[0];
  assign result.tan_y            = o_tan[1];
  assign result.tan_z            = o_tan[2];
  assign result.bitan_x          = o_bit[0];
  assign result.bitan_y          = o_bit[1];
  assign result.bitan_z          = o_bit[2];
  assign result.out_norm_x       = o_nrm[0];
  assign result.out_norm_y       = o_nrm[1];
  assign result.out_norm_z       = o_nrm[2];
  assign result.degenerate       = o_degen;
  assign result.last_of_triangle = o_last;

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= 2'd0;
      corner    <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      // fill the output register, or drop the beat once taken
      if (out_load) res_valid <= 1'b1;
      else if (res_valid && result.ready) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (vertex.valid) begin
            unique case (slot)
              2'd0: begin v0 <= vin; slot <= 2'd1; end
              2'd1: begin v1 <= vin; slot <= 2'd2; end
              2'd2: begin
                v2     <= vin;
                slot   <= 2'd0;
                corner <= 2'd0;
                state  <= S_DIFF;
              end
              default: slot <= 2'd0;
            endcase
          end
        end
        S_DIFF: begin
          e_raw[0] <= sub33(va.px, vc.px);
          e_raw[1] <= sub33(va.py, vc.py);
          e_raw[2] <= sub33(va.pz, vc.pz);
          e_raw[3] <= sub33(vb.px, vc.px);
          e_raw[4] <= sub33(vb.py, vc.py);
          e_raw[5] <= sub33(vb.pz, vc.pz);
          d_raw[0] <= sub33(va.tu, vc.tu);
          d_raw[1] <= sub33(va.tv, vc.tv);
          d_raw[2] <= sub33(vb.tu, vc.tu);
          d_raw[3] <= sub33(vb.tv, vc.tv);
          degen    <= 1'b0;
          state    <= S_FIT;
        end
        S_FIT: begin
          for (int i = 0; i < 6; i++) e[i] <= fit(e_raw[i], e_sh);
          for (int i = 0; i < 4; i++) d[i] <= fit(d_raw[i], d_sh);
          k     <= 4'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          pr    <= mul_out;
          state <= S_ACC;
        end
        S_ACC: begin
          // even steps hold the first product, odd steps take the difference
          if (!k[0]) begin
            acc   <= pr;
            k     <= k + 4'd1;
            state <= S_MUL;
          end else if (k == 4'd1) begin
            if (diff == '0) begin
              degen <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                tn[i] <= '0;
                bn[i] <= '0;
              end
              state <= S_OUT;
            end else begin
              det_neg <= diff[63];
              k       <= k + 4'd1;
              state   <= S_MUL;
            end
          end else if (k <= 4'd7) begin
            tvec[k[2:1] - 2'd1] <= det_neg ? -diff : diff;
            if (k == 4'd7) begin
              state <= S_TNORM;
            end else begin
              k     <= k + 4'd1;
              state <= S_MUL;
            end
          end else begin
            bvec[k[2:1]] <= diff;
            if (k == 4'd13) begin
              state <= S_BNORM;
            end else begin
              k     <= k + 4'd1;
              state <= S_MUL;
            end
          end
        end
        S_TNORM: state <= S_TWAIT;
        S_TWAIT: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              degen <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                tn[i] <= '0;
                bn[i] <= '0;
              end
              state <= S_OUT;
            end else begin
              tn[0] <= unit_x;
              tn[1] <= unit_y;
              tn[2] <= unit_z;
              k     <= 4'd8;
              state <= S_MUL;
            end
          end
        end
        S_BNORM: state <= S_BWAIT;
        S_BWAIT: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              degen <= 1'b1;
              for (int i = 0; i < 3; i++) bn[i] <= '0;
            end else begin
              bn[0] <= unit_x;
              bn[1] <= unit_y;
              bn[2] <= unit_z;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            for (int i = 0; i < 3; i++) begin
              o_tan[i] <= tn[i];
              o_bit[i] <= bn[i];
            end
            o_nrm[0]  <= vc.nx;
            o_nrm[1]  <= vc.ny;
            o_nrm[2]  <= vc.nz;
            o_degen   <= degen;
            o_last    <= (corner == 2'd2);
            if (corner == 2'd2) begin
              state <= S_IDLE;
            end else begin
              corner <= corner + 2'd1;
              state  <= S_DIFF;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TTB_ASSERT_NEVER(a_slot_range, slot == 2'd3, "vertex slot out of range")
  `TTB_ASSERT(a_accept_advances,
    vertex.valid && vertex.ready |=> (slot != 2'd0 || state != S_IDLE),
    "accepted vertex did not advance the triangle")
  `TTB_ASSERT(a_nondegen_tangent,
    result.valid && !result.degenerate |->
      (result.tan_x != 0 || result.tan_y != 0 || result.tan_z != 0),
    "zero tangent without degenerate flag")
  `TTB_ASSERT(a_norm_done_waited,
    nstat.done |-> (state == S_TWAIT || state == S_BWAIT),
    "normalizer finished while nobody waited")

endmodule

// ===== sv/ttb_norm.sv =====
// Iterative 3-vector normalizer: block shift, sum of squares, bit-pair root, serial divide.
`include "assert_macros.svh"

module ttb_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ttb_pkg::VEC_W-1:0]    vec_x,
  input  logic signed [ttb_pkg::VEC_W-1:0]    vec_y,
  input  logic signed [ttb_pkg::VEC_W-1:0]    vec_z,
  output ttb_pkg::norm_stat_t                 stat,
  output logic signed [ttb_pkg::NRM_W-1:0]    unit_x,
  output logic signed [ttb_pkg::NRM_W-1:0]    unit_y,
  output logic signed [ttb_pkg::NRM_W-1:0]    unit_z
);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_ACC, N_ROOT, N_DLOAD, N_DIV, N_STORE
  } nstate_t;

  nstate_t state;
  logic [62:0] mag [3];
  logic [2:0]  neg;
  logic [1:0]  idx;
  logic [59:0] sq;
  logic [61:0] sum;
  logic [61:0] rad;
  logic [63:0] root;
  logic [62:0] bitm;
  logic [44:0] num;
  logic [31:0] rem;
  logic [3:0]  j;
  logic [14:0] q;
  logic        fin;
  logic signed [ttb_pkg::NRM_W-1:0] unit [3];

  logic [62:0] mag_or;
  logic [62:0] abs_x, abs_y, abs_z;
  logic [63:0] root_try;
  logic [61:0] sum_next;
  logic [31:0] len;
  logic [44:0] num_init;
  logic [32:0] trial;
  logic [15:0] q_ext;
  logic        vec_zero;
  logic        done_set;

  function automatic logic [62:0] abs64(logic signed [63:0] v);
    logic [63:0] n;
    n = v[63] ? 64'(-v) : 64'(v);
    return n[62:0];
  endfunction

  // Magnitudes, root trial, division trial
  always_comb begin
    abs_x    = abs64(vec_x);
    abs_y    = abs64(vec_y);
    abs_z    = abs64(vec_z);
    vec_zero = ((abs_x | abs_y | abs_z) == '0);
    mag_or   = mag[0] | mag[1] | mag[2];
    root_try = root + {1'b0, bitm};
    sum_next = sum + {2'b0, sq};
    len      = root[31:0];
    num_init = {1'b0, mag[idx][29:0], 14'd0} + {14'd0, root[31:1]};
    trial    = {rem, num[j]};
    q_ext    = {1'b0, q};
    done_set = ((state == N_IDLE) && start && vec_zero) ||
               ((state == N_STORE) && (idx == 2'd2));
  end

  assign unit_x = unit[0];
  assign unit_y = unit[1];
  assign unit_z = unit[2];

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      stat  <= '0;
      fin   <= 1'b0;
    end else begin
      stat.done <= done_set;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            mag[0] <= abs_x;
            mag[1] <= abs_y;
            mag[2] <= abs_z;
            neg    <= {vec_z[63], vec_y[63], vec_x[63]};
            if (vec_zero) begin
              stat.zero <= 1'b1;
              unit[0]   <= '0;
              unit[1]   <= '0;
              unit[2]   <= '0;
            end else begin
              stat.zero <= 1'b0;
              state     <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (|mag_or[62:30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!mag_or[29]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            idx   <= 2'd0;
            sum   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq    <= mag[idx][29:0] * mag[idx][29:0];
          state <= N_ACC;
        end
        N_ACC: begin
          sum <= sum_next;
          if (idx == 2'd2) begin
            rad   <= sum_next;
            root  <= '0;
            bitm  <= {1'b1, 62'd0};
            state <= N_ROOT;
          end else begin
            idx   <= idx + 2'd1;
            state <= N_SQ;
          end
        end
        N_ROOT: begin
          // one bit pair of the integer square root per cycle
          if ({2'b0, rad} >= root_try) begin
            rad  <= rad - root_try[61:0];
            root <= (root >> 1) + {1'b0, bitm};
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            idx   <= 2'd0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          num   <= num_init;
          rem   <= {2'b0, num_init[44:15]};
          j     <= 4'd14;
          state <= N_DIV;
        end
        N_DIV: begin
          // one quotient bit per cycle
          if (trial >= {1'b0, len}) begin
            rem  <= 32'(trial - {1'b0, len});
            q[j] <= 1'b1;
          end else begin
            rem  <= trial[31:0];
            q[j] <= 1'b0;
          end
          if (j == 4'd0) state <= N_STORE;
          else           j     <= j - 4'd1;
        end
        N_STORE: begin
          unit[idx] <= neg[idx] ? -q_ext : q_ext;
          if (idx == 2'd2) begin
            fin   <= ~fin;
            state <= N_IDLE;
          end else begin
            idx   <= idx + 2'd1;
            state <= N_DLOAD;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  // Unit vector component never exceeds one
  `TTB_ASSERT(a_unit_bound,
    stat.done && !stat.zero |-> (q_ext <= 16'd16384), "normalizer quotient above one")
  // A zero result only comes straight from the idle state
  `TTB_ASSERT(a_zero_from_idle,
    stat.done && stat.zero |-> $past(state) == N_IDLE, "zero flag set after a full pass")
  // A full pass ends with the last component stored
  `TTB_ASSERT(a_full_pass,
    $changed(fin) |-> $past(state) == N_STORE && $past(idx) == 2'd2, "pass end out of order")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the triangle tangent basis block.
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES = 3000;
  localparam int RAND_TRIS = 50;
  localparam longint unsigned LIM30 = 64'd1 << 30;
  localparam longint unsigned LIM29 = 64'd1 << 29;
  localparam int ONE = 65536;
  localparam int UNIT = 16384;

  typedef struct {
    logic signed [ttb_pkg::NRM_W-1:0] t[3];
    logic signed [ttb_pkg::NRM_W-1:0] b[3];
    logic signed [ttb_pkg::NRM_W-1:0] n[3];
    logic dg;
    logic last;
  } basis_t;

  typedef struct {
    ttb_pkg::vert_t v;
    bit typed;
    logic signed [ttb_pkg::NRM_W-1:0] t[3];
    logic signed [ttb_pkg::NRM_W-1:0] b[3];
    bit dg;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int errors = 0;
  int beats_seen = 0;
  bit calm = 1'b0;
  bit held_off = 1'b0;
  int hold_left = 0;
  int gap_left = 0;

  basis_t basis_q[$];
  row_t rows[$];
  ttb_pkg::vert_t corner_buf[2];
  int corner_cnt = 0;

  ttb_vertex_if vtx();
  ttb_result_if res();

  triangle_tangent_basis u_top (
    .clk    (clk),
    .rst    (rst),
    .vertex (vtx),
    .result (res)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  // Shift a group of n values toward zero until all magnitudes are below 2^30.
  function automatic void fit30(inout longint g[6], input int n);
    longint unsigned mx;
    int s;
    mx = 0;
    s = 0;
    for (int i = 0; i < n; i++) if (mag(g[i]) > mx) mx = mag(g[i]);
    while ((mx >> s) >= LIM30) s++;
    for (int i = 0; i < n; i++) g[i] = g[i] < 0 ? -longint'(mag(g[i]) >> s) : g[i] >>> s;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Scale a vector to Q1.14 unit length; 0 for the zero vector.
  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx, acc, len;
    longint q;
    mx = 0;
    acc = 0;
    o = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= LIM30) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < LIM29) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) acc += m[i] * m[i];
    len = root64(acc);
    for (int i = 0; i < 3; i++) begin
      q = longint'((m[i] * UNIT + len / 2) / len);
      o[i] = v[i] < 0 ? -q : q;
    end
    return 1'b1;
  endfunction

  // Hold the first two corners; on the third, queue one basis per corner.
  task automatic predict_basis(input row_t r);
    ttb_pkg::vert_t c[3];
    longint p[3][3], uv[3][2], nr[3][3];
    longint e[6], d[6], tv[3], tn[3], bv[3], bn[3], det;
    int a, b;
    bit dg;
    basis_t x;
    if (corner_cnt < 2) begin
      corner_buf[corner_cnt] = r.v;
      corner_cnt++;
      return;
    end
    corner_cnt = 0;
    c[0] = corner_buf[0];
    c[1] = corner_buf[1];
    c[2] = r.v;
    for (int k = 0; k < 3; k++) begin
      p[k] = '{c[k].px, c[k].py, c[k].pz};
      uv[k] = '{c[k].tu, c[k].tv};
      nr[k] = '{c[k].nx, c[k].ny, c[k].nz};
    end
    for (int k = 0; k < 3; k++) begin
      a = (k == 0) ? 1 : (k == 1) ? 0 : 1;
      b = (k == 2) ? 0 : 2;
      for (int i = 0; i < 3; i++) begin
        e[i] = p[a][i] - p[k][i];
        e[3+i] = p[b][i] - p[k][i];
      end
      d = '{uv[a][0] - uv[k][0], uv[a][1] - uv[k][1],
            uv[b][0] - uv[k][0], uv[b][1] - uv[k][1], 0, 0};
      fit30(e, 6);
      fit30(d, 4);
      det = d[0] * d[3] - d[2] * d[1];
      tn = '{0, 0, 0};
      bn = '{0, 0, 0};
      dg = 1'b0;
      if (det == 0) begin
        dg = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          tv[i] = d[3] * e[i] - d[1] * e[3+i];
          if (det < 0) tv[i] = -tv[i];
        end
        if (!unit_vec(tv, tn)) begin
          dg = 1'b1;
        end else begin
          bv[0] = nr[k][1] * tn[2] - nr[k][2] * tn[1];
          bv[1] = nr[k][2] * tn[0] - nr[k][0] * tn[2];
          bv[2] = nr[k][0] * tn[1] - nr[k][1] * tn[0];
          if (!unit_vec(bv, bn)) dg = 1'b1;
        end
      end
      for (int i = 0; i < 3; i++) begin
        x.t[i] = r.typed ? r.t[i] : ttb_pkg::NRM_W'(tn[i]);
        x.b[i] = r.typed ? r.b[i] : ttb_pkg::NRM_W'(bn[i]);
        x.n[i] = ttb_pkg::NRM_W'(nr[k][i]);
      end
      x.dg = r.typed ? r.dg : dg;
      x.last = (k == 2);
      basis_q = {basis_q, x};
    end
  endtask

  function automatic ttb_pkg::vert_t mk(int px, int py, int pz, int tu, int tv,
                                        int nx, int ny, int nz);
    ttb_pkg::vert_t v;
    v = '{px: px, py: py, pz: pz, tu: tu, tv: tv,
          nx: ttb_pkg::NRM_W'(nx), ny: ttb_pkg::NRM_W'(ny), nz: ttb_pkg::NRM_W'(nz)};
    return v;
  endfunction

  task automatic add_row(input ttb_pkg::vert_t v, input bit typed = 0,
                         input int t0 = 0, input int t1 = 0, input int t2 = 0,
                         input int b0 = 0, input int b1 = 0, input int b2 = 0,
                         input bit dg = 0);
    row_t r;
    r.v = v;
    r.typed = typed;
    r.t = '{ttb_pkg::NRM_W'(t0), ttb_pkg::NRM_W'(t1), ttb_pkg::NRM_W'(t2)};
    r.b = '{ttb_pkg::NRM_W'(b0), ttb_pkg::NRM_W'(b1), ttb_pkg::NRM_W'(b2)};
    r.dg = dg;
    rows = {rows, r};
  endtask

  // Right triangle in the xy plane with uv matching position, normal n; flat_pos puts all corners at the origin
  task automatic add_unit_tri(input int nx, input int ny, input int nz, input bit typed,
                              input int t0, input int b1, input bit dg, input bit flat_pos);
    int s;
    s = flat_pos ? 0 : ONE;
    add_row(mk(0, 0, 0, 0, 0, nx, ny, nz));
    add_row(mk(s, 0, 0, ONE, 0, nx, ny, nz));
    add_row(mk(0, s, 0, 0, ONE, nx, ny, nz), typed, t0, 0, 0, 0, b1, 0, dg);
  endtask

  function automatic int rcoord(bit wide);
    return wide ? int'($urandom) : int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic int rnorm(bit wide);
    return wide ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 2 * UNIT)) - UNIT;
  endfunction

  function automatic ttb_pkg::vert_t rvert(bit wide, bit wide_n);
    return mk(rcoord(wide), rcoord(wide), rcoord(wide), rcoord(wide), rcoord(wide),
              rnorm(wide_n), rnorm(wide_n), rnorm(wide_n));
  endfunction

  task automatic send_vertex(input row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= r.v.px;
    vtx.pos_y <= r.v.py;
    vtx.pos_z <= r.v.pz;
    vtx.tex_u <= r.v.tu;
    vtx.tex_v <= r.v.tv;
    vtx.norm_x <= r.v.nx;
    vtx.norm_y <= r.v.ny;
    vtx.norm_z <= r.v.nz;
    do @(posedge clk); while (!vtx.ready);
    predict_basis(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Hold the receiver off once for a long stretch
  always @(posedge clk) begin
    if (!held_off && beats_seen >= 30) begin
      held_off <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Compare each result beat with the oldest queued basis, then pace ready
  always @(posedge clk) begin
    basis_t want;
    if (!rst && res.valid && res.ready) begin
      beats_seen++;
      if (basis_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat expected none actual tan_x %0d", $time, res.tan_x);
      end else begin
        want = basis_q.pop_front();
        check_field("tan_x", want.t[0], res.tan_x);
        check_field("tan_y", want.t[1], res.tan_y);
        check_field("tan_z", want.t[2], res.tan_z);
        check_field("bitan_x", want.b[0], res.bitan_x);
        check_field("bitan_y", want.b[1], res.bitan_y);
        check_field("bitan_z", want.b[2], res.bitan_z);
        check_field("out_norm_x", want.n[0], res.out_norm_x);
        check_field("out_norm_y", want.n[1], res.out_norm_y);
        check_field("out_norm_z", want.n[2], res.out_norm_z);
        check_field("degenerate", want.dg, res.degenerate);
        check_field("last_of_triangle", want.last, res.last_of_triangle);
      end
      gap_left = calm ? 0 : $urandom_range(0, 9);
    end
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  initial begin
    int mode;
    ttb_pkg::vert_t v0, v1, v2;
    row_t r;
    vtx.valid = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.tex_u = '0;
    vtx.tex_v = '0;
    vtx.norm_x = '0;
    vtx.norm_y = '0;
    vtx.norm_z = '0;
    res.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: known bases, degenerate cases, extremes
    add_unit_tri(0, 0, UNIT, 1, UNIT, UNIT, 0, 0);
    add_row(mk(0, 0, 0, 7, 9, 0, 0, UNIT));
    add_row(mk(ONE, 0, 0, 7, 9, 0, UNIT, 0));
    add_row(mk(0, ONE, 0, 7, 9, UNIT, 0, 0), 1, 0, 0, 0, 0, 0, 0, 1);
    add_unit_tri(0, 0, UNIT, 1, 0, 0, 1, 1);
    add_unit_tri(UNIT, 0, 0, 1, UNIT, 0, 1, 0);
    add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, UNIT, 0, 0));
    add_row(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, ONE, 0, 0, -UNIT, 0));
    add_row(mk(0, 0, 32'h8000_0000, 0, ONE, 0, 0, -UNIT));
    add_row(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -32768, 32767, -1));
    add_row(mk(ONE, 0, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32767, -32768, 0));
    add_row(mk(5, ONE, 0, 0, 0, -32768, -32768, 32767));
    add_row(mk(0, 0, 0, 0, 0, 0, 0, -UNIT));
    add_row(mk(0, ONE, 0, ONE, 0, 0, 0, -UNIT));
    add_row(mk(ONE, 0, 0, 0, ONE, 0, 0, -UNIT));
    foreach (rows[i]) begin
      calm = (i >= 9);
      send_vertex(rows[i]);
    end

    // Random triangles, with occasional degenerate shapes
    for (int k = 0; k < RAND_TRIS; k++) begin
      calm = (k % 10 < 2);
      mode = $urandom_range(0, 11);
      v0 = rvert(mode == 3 || mode == 4, mode == 5);
      v1 = rvert(mode == 3 || mode == 6, mode == 5);
      v2 = rvert(mode == 4 || mode == 6, mode == 7);
      if (mode == 0) begin
        v1.tu = v0.tu; v1.tv = v0.tv; v2.tu = v0.tu; v2.tv = v0.tv;
      end
      if (mode == 1) begin
        v1.px = v0.px; v1.py = v0.py; v1.pz = v0.pz;
        v2.px = v0.px; v2.py = v0.py; v2.pz = v0.pz;
      end
      if (mode == 2) begin
        v2.tu = 2 * v1.tu - v0.tu; v2.tv = 2 * v1.tv - v0.tv;
      end
      r.typed = 0;
      r.v = v0; send_vertex(r);
      r.v = v1; send_vertex(r);
      r.v = v2; send_vertex(r);
    end
    vtx.valid <= 1'b0;

    while (basis_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ttb_pkg.sv
sv/ttb_if.sv
sv/ttb_norm.sv
sv/triangle_tangent_basis.sv
tb/tb_top.sv
